@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/fpsr_pkg.sv @@
// ----------------------------------------------------------------------------
// fpsr_pkg
// Types and constants shared by the pattern replace stream block.
// ----------------------------------------------------------------------------
package fpsr_pkg;

   localparam int unsigned WINDOW_BYTES = 11;
   localparam int unsigned WIN_BITS     = 8 * WINDOW_BYTES;
   localparam int unsigned FILL_W       = $clog2(WINDOW_BYTES + 1);
   localparam int unsigned FIRST_BITS   = 64;
   localparam int unsigned LAST_BITS    = WIN_BITS - FIRST_BITS;

   localparam int unsigned CSR_ADDR_W   = 4;
   localparam int unsigned CSR_DATA_W   = 64;
   localparam int unsigned REG_SEL_BIT  = 3;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // Replacement text, first character in the most significant byte.
   localparam logic [WIN_BITS-1:0] REPLACE_TEXT = "AUTORUN SYS";

   typedef logic [WIN_BITS-1:0] pattern_type;

   typedef enum logic {
      REG_PATTERN_FIRST = 1'b0,
      REG_PATTERN_LAST  = 1'b1
   } reg_index_type;

   typedef enum logic {
      FRONT_STREAM,
      FRONT_FLUSH
   } front_state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       replaced_any;
   } q_entry_type;

   typedef struct packed {
      logic        valid;
      q_entry_type entry;
   } q_push_type;

endpackage

@@ rtl/core/fpsr_ifs.sv @@
// ----------------------------------------------------------------------------
// fpsr stream interfaces
// Valid/ready channels for image bytes in and processed bytes out.
// ----------------------------------------------------------------------------
interface fpsr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_image;

   modport source (output valid, output data_byte, output end_of_image, input ready);
   modport sink   (input valid, input data_byte, input end_of_image, output ready);
endinterface

interface fpsr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic       replaced_any;

   modport source (output valid, output out_byte, output out_last, output replaced_any,
                   input ready);
   modport sink   (input valid, input out_byte, input out_last, input replaced_any,
                   output ready);
endinterface

@@ rtl/core/fpsr_csr.sv @@
// ----------------------------------------------------------------------------
// fpsr_csr
// APB-style register file holding the 11-byte search pattern.
// ----------------------------------------------------------------------------
module fpsr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [fpsr_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [fpsr_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [fpsr_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready,
   output fpsr_pkg::pattern_type                pattern
);
   import fpsr_pkg::*;

   logic [FIRST_BITS-1:0] first_ff, first_in;
   logic [LAST_BITS-1:0]  last_ff, last_in;
   logic                  wr_en;
   reg_index_type         sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign sel     = reg_index_type'(paddr[REG_SEL_BIT]);
   assign pattern = {first_ff, last_ff};

   always_comb begin
      first_in = first_ff;
      last_in  = last_ff;
      prdata   = '0;
      unique case (sel)
         REG_PATTERN_FIRST: begin
            prdata = first_ff;
            if (wr_en) begin
               first_in = pwdata[FIRST_BITS-1:0];
            end
         end
         REG_PATTERN_LAST: begin
            prdata = {{(CSR_DATA_W-LAST_BITS){1'b0}}, last_ff};
            if (wr_en) begin
               last_in = pwdata[LAST_BITS-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         last_ff  <= '0;
      end else begin
         first_ff <= first_in;
         last_ff  <= last_in;
      end
   end

endmodule

@@ rtl/core/fpsr_front.sv @@
// ----------------------------------------------------------------------------
// fpsr_front
// Accepts image bytes, keeps the 11-byte window, detects and replaces
// pattern matches and pushes outgoing bytes into the queue.
// ----------------------------------------------------------------------------
module fpsr_front (
   input  logic                  clock,
   input  logic                  reset,
   fpsr_req_if.sink              req_chan,
   input  fpsr_pkg::pattern_type pattern,
   input  logic                  q_full,
   output fpsr_pkg::q_push_type  q_push
);
   import fpsr_pkg::*;

   front_state_type   state_ff, state_in;
   logic [7:0]        win_ff [WINDOW_BYTES];
   logic [7:0]        win_in [WINDOW_BYTES];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] skip_ff, skip_in;
   logic              seen_ff, seen_in;

   logic              accept;
   logic              flush_step;
   logic              was_full;
   logic              hit;
   logic [FILL_W-1:0] skip_dec;
   logic [FILL_W-1:0] fill_after;
   logic [7:0]        appended [WINDOW_BYTES];
   logic [7:0]        shifted  [WINDOW_BYTES];
   pattern_type       appended_flat;

   assign accept = req_chan.valid & req_chan.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FRONT_STREAM: begin
            if (accept && req_chan.end_of_image) begin
               state_in = FRONT_FLUSH;
            end
         end
         FRONT_FLUSH: begin
            if (flush_step && fill_ff == FILL_W'(1)) begin
               state_in = FRONT_STREAM;
            end
         end
         default: begin
            state_in = FRONT_STREAM;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      req_chan.ready = 1'b0;
      flush_step     = 1'b0;
      unique case (state_ff)
         FRONT_STREAM: req_chan.ready = !q_full;
         FRONT_FLUSH:  flush_step     = !q_full;
         default:      req_chan.ready = 1'b0;
      endcase
   end

   // Window after appending the new byte, and after dropping the oldest.
   always_comb begin
      was_full   = (fill_ff == FILL_W'(WINDOW_BYTES));
      skip_dec   = (skip_ff != '0) ? skip_ff - FILL_W'(1) : skip_ff;
      fill_after = was_full ? FILL_W'(WINDOW_BYTES) : fill_ff + FILL_W'(1);
      for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
         shifted[i]  = win_ff[i+1];
         appended[i] = was_full ? win_ff[i+1]
                     : ((fill_ff == FILL_W'(i)) ? req_chan.data_byte : win_ff[i]);
      end
      shifted[WINDOW_BYTES-1]  = win_ff[WINDOW_BYTES-1];
      appended[WINDOW_BYTES-1] = (was_full || fill_ff == FILL_W'(WINDOW_BYTES-1))
                               ? req_chan.data_byte : win_ff[WINDOW_BYTES-1];
      for (int i = 0; i < WINDOW_BYTES; i++) begin
         appended_flat[WIN_BITS-1-8*i -: 8] = appended[i];
      end
      // Only a full window outside the tail of an earlier replacement can match.
      hit = (fill_after == FILL_W'(WINDOW_BYTES)) && (skip_dec == '0)
            && (appended_flat == pattern);
   end

   // Datapath updates and queue pushes.
   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      skip_in = skip_ff;
      seen_in = seen_ff;
      q_push  = '0;
      if (accept) begin
         fill_in = fill_after;
         if (hit) begin
            for (int i = 0; i < WINDOW_BYTES; i++) begin
               win_in[i] = REPLACE_TEXT[WIN_BITS-1-8*i -: 8];
            end
            skip_in = FILL_W'(WINDOW_BYTES);
            seen_in = 1'b1;
         end else begin
            win_in  = appended;
            skip_in = skip_dec;
         end
         q_push.valid              = was_full;
         q_push.entry.out_byte     = win_ff[0];
         q_push.entry.out_last     = 1'b0;
         q_push.entry.replaced_any = seen_ff | hit;
      end else if (flush_step) begin
         win_in                    = shifted;
         fill_in                   = fill_ff - FILL_W'(1);
         q_push.valid              = 1'b1;
         q_push.entry.out_byte     = win_ff[0];
         q_push.entry.out_last     = (fill_ff == FILL_W'(1));
         q_push.entry.replaced_any = seen_ff;
         if (fill_ff == FILL_W'(1)) begin
            skip_in = '0;
            seen_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_STREAM;
         fill_ff  <= '0;
         skip_ff  <= '0;
         seen_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         skip_ff  <= skip_in;
         seen_ff  <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

@@ rtl/core/fpsr_back.sv @@
// ----------------------------------------------------------------------------
// fpsr_back
// Byte queue behind the window logic and the registered output stage
// that drives the result channel.
// ----------------------------------------------------------------------------
module fpsr_back #(
   parameter int unsigned QUEUE_DEPTH = fpsr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fpsr_pkg::q_push_type q_push,
   output logic                 q_full,
   fpsr_rsp_if.source           rsp_chan
);
   import fpsr_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   q_entry_type      slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   q_entry_type      rsp_entry_ff;
   logic             pop;

   assign q_full = (count_ff == CNT_W'(QUEUE_DEPTH));
   // With a byte queued, the output register reloads when empty or being taken.
   assign pop    = (count_ff != '0) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (q_push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in     = count_ff + CNT_W'(q_push.valid) - CNT_W'(pop);
      rsp_valid_in = pop ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.valid) begin
         slot_ff[wr_ptr_ff] <= q_push.entry;
      end
      if (pop) begin
         rsp_entry_ff <= slot_ff[rd_ptr_ff];
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_byte     = rsp_entry_ff.out_byte;
   assign rsp_chan.out_last     = rsp_entry_ff.out_last;
   assign rsp_chan.replaced_any = rsp_entry_ff.replaced_any;

endmodule

@@ rtl/core/fixed_pattern_stream_replace.sv @@
// ----------------------------------------------------------------------------
// fixed_pattern_stream_replace
// Streams image bytes through an 11-byte window and replaces every
// non-overlapping occurrence of the configured pattern with "AUTORUN SYS".
// ----------------------------------------------------------------------------
// Usage: image bytes enter on req_chan (data_byte, end_of_image) and leave on
// rsp_chan (out_byte, out_last, replaced_any). The pattern is written over
// the APB port: register 0 at byte address 0 holds pattern bytes 1..8, the
// first byte in the top bits; register 1 at byte address 8 holds bytes 9..11.
// Write the pattern only while no image is in flight.
// Throughput: one byte per cycle while the stream runs and the queue is not
// full; the first 11 bytes of an image only fill the window. A byte pushed
// out of the full window is written into the queue when the byte that
// displaced it is accepted, and reaches rsp_chan through the output register.
// The byte marked end_of_image starts a flush of the window, one byte per
// cycle while the queue is not full, and req_chan.ready stays low until the
// last window byte has entered the output queue.
// When rsp_chan stalls, the output register holds its byte and the queue
// fills; once it is full req_chan.ready drops. Reset empties the window and
// the queue and clears the pattern registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fixed_pattern_stream_replace #(
   parameter int unsigned QUEUE_DEPTH = fpsr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   fpsr_req_if.sink                        req_chan,
   fpsr_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fpsr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fpsr_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [fpsr_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import fpsr_pkg::*;

   pattern_type pattern;
   q_push_type  q_push;
   logic        q_full;
   logic        in_take;
   logic        last_take;

   fpsr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .pattern (pattern)
   );

   fpsr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .pattern  (pattern),
      .q_full   (q_full),
      .q_push   (q_push)
   );

   fpsr_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_full   (q_full),
      .rsp_chan (rsp_chan)
   );

   assign in_take   = req_chan.valid & req_chan.ready;
   assign last_take = in_take & req_chan.end_of_image;

   `ASSERT_SAME_CYCLE(a_no_push_when_full, clock, reset, q_push.valid, !q_full, "queue overflow")
   `ASSERT_SAME_CYCLE(a_accept_needs_space, clock, reset, in_take, !q_full, "accept while full")
   `ASSERT_NEXT_CYCLE(a_flush_blocks_input, clock, reset, last_take, !req_chan.ready, "in flush")

endmodule
